>>> rtl/core/bdme_pkg.sv
// Shared types, constants and a helper function for the bin density move evaluator.
package bdme_pkg;

  // Default grid limits handed to the top level.
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Field and datapath widths.
  localparam int POS_W  = 24;  // signed die coordinates and bin edges
  localparam int SPAN_W = 12;  // overlap of one rectangle with one bin pitch
  localparam int AREA_W = 24;  // overlap area of one rectangle with one bin
  localparam int OCC_W  = 31;  // stored occupancy
  localparam int CAP_W  = 24;
  localparam int OVA_W  = 54;  // overflow accumulator, wide enough for any grid size
  localparam int OVF_W  = 33;  // reported overflow delta
  localparam int SQ_W   = 64;

  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

  // Commands.
  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BINS_ACROSS = 3'd0,
    REG_BINS_DOWN   = 3'd1,
    REG_BIN_WIDTH   = 3'd2,
    REG_BIN_HEIGHT  = 3'd3,
    REG_CAPACITY    = 3'd4
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_UPDATE,
    ST_SQ_NEW,
    ST_SQ_OLD,
    ST_ACC,
    ST_FINISH
  } state_t;

  // Results of one occupancy update.
  typedef struct packed {
    logic [OCC_W-1:0] nocc;
    logic [OCC_W-1:0] excess_before;
    logic [OCC_W-1:0] excess_after;
    logic             clip;
  } occ_upd_t;

  // Length of the overlap of span [lo,hi) with span [blo,bhi).
  function automatic logic [SPAN_W-1:0] span_overlap(
    input logic signed [POS_W-1:0] lo,
    input logic signed [POS_W-1:0] hi,
    input logic signed [POS_W-1:0] blo,
    input logic signed [POS_W-1:0] bhi
  );
    logic signed [POS_W-1:0] a;
    logic signed [POS_W-1:0] b;
    logic signed [POS_W-1:0] d;
    a = (lo > blo) ? lo : blo;
    b = (hi < bhi) ? hi : bhi;
    d = b - a;
    return (b > a) ? d[SPAN_W-1:0] : '0;
  endfunction

endpackage

>>> rtl/core/bin_density_move_evaluator.sv
// Top level of the bin density move evaluator: sequencer, occupancy memory and shared multiplier.
//
// The block keeps one occupancy word per bin in a single-port memory of MAX_COLS*MAX_ROWS
// entries and handles one request at a time. A place, evaluate or commit request walks
// every bin of the grid in use, row by row; its pace is set by the one multiplier that
// forms both overlap areas and both squared excesses of a bin in turn. A clear request
// sweeps the memory one entry a cycle. After reset the same sweep runs once before the
// first request is taken (in_stall stays high); configuration writes are taken at any
// time but belong only between requests. The result register lets the next request
// start while a result still waits for the output side.
module bin_density_move_evaluator #(
  parameter int MAX_COLS = bdme_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bdme_pkg::MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  // Request channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [15:0]         width,
  input  logic [15:0]         height,
  input  logic signed [17:0]  old_left,
  input  logic signed [17:0]  old_bottom,
  input  logic signed [17:0]  new_left,
  input  logic signed [17:0]  new_bottom,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [32:0]  overflow_delta,
  output logic signed [63:0]  excess_square_delta,
  output logic                saturated
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CXW   = $clog2(MAX_COLS + 1);
  localparam int CYW   = $clog2(MAX_ROWS + 1);
  localparam int PW    = bdme_pkg::POS_W;
  localparam int OW    = bdme_pkg::OCC_W;
  localparam int MW    = 2 * OW;

  // Configuration registers.
  logic [6:0]  bins_across;
  logic [6:0]  bins_down;
  logic [11:0] bin_width;
  logic [11:0] bin_height;
  logic [bdme_pkg::CAP_W-1:0] capacity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_across <= 7'd64;
      bins_down   <= 7'd64;
      bin_width   <= 12'd64;
      bin_height  <= 12'd64;
      capacity    <= 24'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bdme_pkg::reg_idx_t'(cfg_index))
        bdme_pkg::REG_BINS_ACROSS: bins_across <= cfg_data[6:0];
        bdme_pkg::REG_BINS_DOWN:   bins_down   <= cfg_data[6:0];
        bdme_pkg::REG_BIN_WIDTH:   bin_width   <= cfg_data[11:0];
        bdme_pkg::REG_BIN_HEIGHT:  bin_height  <= cfg_data[11:0];
        bdme_pkg::REG_CAPACITY:    capacity    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective grid size and pitch.
  logic [10:0] across_ext;
  logic [10:0] down_ext;
  logic [10:0] cols_full;
  logic [10:0] rows_full;
  logic [CXW-1:0] cols;
  logic [CYW-1:0] rows;
  logic [11:0] pitch_x;
  logic [11:0] pitch_y;

  always_comb begin
    across_ext = {4'd0, bins_across};
    down_ext   = {4'd0, bins_down};
    if (across_ext == 11'd0) begin
      cols_full = 11'd1;
    end else if (across_ext > 11'(MAX_COLS)) begin
      cols_full = 11'(MAX_COLS);
    end else begin
      cols_full = across_ext;
    end
    if (down_ext == 11'd0) begin
      rows_full = 11'd1;
    end else if (down_ext > 11'(MAX_ROWS)) begin
      rows_full = 11'(MAX_ROWS);
    end else begin
      rows_full = down_ext;
    end
    cols = cols_full[CXW-1:0];
    rows = rows_full[CYW-1:0];
    pitch_x = (bin_width == 12'd0) ? 12'd1 : bin_width;
    pitch_y = (bin_height == 12'd0) ? 12'd1 : bin_height;
  end

  // Sequencer and datapath registers.
  bdme_pkg::state_t state, state_next;
  bdme_pkg::cmd_t   cmd;
  logic             clr_reply;
  logic signed [PW-1:0] rect_w, rect_h, ol, ob, nl, nb;
  logic [CXW-1:0]   bx;
  logic [CYW-1:0]   by;
  logic signed [PW-1:0] bl, bb;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    row_base;
  logic [bdme_pkg::SPAN_W-1:0] oy_new, oy_old, ox_new, ox_old;
  logic [MW-1:0]    mul_p;
  logic [bdme_pkg::AREA_W-1:0] a_new;
  logic [OW-1:0]    nocc_r, oex_r, nex_r;
  logic             nz_r;
  logic [MW-1:0]    sq_new;
  logic signed [bdme_pkg::OVA_W-1:0] ovf_acc;
  logic signed [bdme_pkg::SQ_W-1:0]  sq_acc;
  logic             sat_acc;

  logic last_col, last_row, last_addr;
  logic use_old, write_back;
  assign last_col  = (bx == cols - CXW'(1));
  assign last_row  = (by == rows - CYW'(1));
  assign last_addr = (addr == AW'(DEPTH - 1));
  assign use_old    = (cmd != bdme_pkg::CMD_PLACE);
  assign write_back = (cmd == bdme_pkg::CMD_PLACE) || (cmd == bdme_pkg::CMD_COMMIT);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Occupancy memory.
  logic [OW-1:0] mem [DEPTH];
  logic [OW-1:0] rdata;
  logic          mem_we;
  logic [OW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rdata <= mem[addr];
  end

  // Occupancy update of the current bin.
  logic signed [bdme_pkg::AREA_W:0] delta;
  bdme_pkg::occ_upd_t upd;
  assign delta = $signed({1'b0, a_new}) - $signed({1'b0, mul_p[bdme_pkg::AREA_W-1:0]});

  bdme_occ_update u_occ_update (
    .occ      (rdata),
    .delta    (delta),
    .capacity (capacity),
    .upd      (upd)
  );

  // Shared multiplier operands.
  logic [OW-1:0] mul_a, mul_b;
  always_comb begin
    case (state)
      bdme_pkg::ST_MUL_NEW: begin
        mul_a = OW'(ox_new);
        mul_b = OW'(oy_new);
      end
      bdme_pkg::ST_MUL_OLD: begin
        mul_a = OW'(ox_old);
        mul_b = OW'(oy_old);
      end
      bdme_pkg::ST_SQ_NEW: begin
        mul_a = nex_r;
        mul_b = nex_r;
      end
      default: begin
        mul_a = oex_r;
        mul_b = oex_r;
      end
    endcase
  end

  // Saturating accumulation of the squared excess change.
  localparam int SQ_W_P1 = bdme_pkg::SQ_W;
  logic signed [MW:0]   sq_diff;
  logic signed [SQ_W_P1:0] sq_sum;
  logic signed [bdme_pkg::SQ_W-1:0] sq_sat;
  logic sq_clip;
  always_comb begin
    sq_diff = $signed({1'b0, sq_new}) - $signed({1'b0, mul_p});
    sq_sum  = {sq_acc[bdme_pkg::SQ_W-1], sq_acc} + (SQ_W_P1 + 1)'(sq_diff);
    sq_clip = (sq_sum[SQ_W_P1] != sq_sum[SQ_W_P1-1]);
    if (!sq_clip) begin
      sq_sat = sq_sum[bdme_pkg::SQ_W-1:0];
    end else if (sq_sum[SQ_W_P1]) begin
      sq_sat = {1'b1, {(bdme_pkg::SQ_W-1){1'b0}}};
    end else begin
      sq_sat = {1'b0, {(bdme_pkg::SQ_W-1){1'b1}}};
    end
  end

  // Overflow clamp to the reported range.
  localparam logic signed [bdme_pkg::OVA_W-1:0] OVF_HI =
    bdme_pkg::OVA_W'({1'b0, {(bdme_pkg::OVF_W-1){1'b1}}});
  localparam logic signed [bdme_pkg::OVA_W-1:0] OVF_LO = -OVF_HI - 1;
  logic signed [bdme_pkg::OVF_W-1:0] ovf_out;
  logic ovf_clip;
  always_comb begin
    ovf_clip = 1'b1;
    if (ovf_acc > OVF_HI) begin
      ovf_out = OVF_HI[bdme_pkg::OVF_W-1:0];
    end else if (ovf_acc < OVF_LO) begin
      ovf_out = OVF_LO[bdme_pkg::OVF_W-1:0];
    end else begin
      ovf_out = ovf_acc[bdme_pkg::OVF_W-1:0];
      ovf_clip = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bdme_pkg::ST_CLEAR:   if (last_addr) state_next = clr_reply ? bdme_pkg::ST_FINISH
                                                                  : bdme_pkg::ST_IDLE;
      bdme_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (bdme_pkg::cmd_t'(command) == bdme_pkg::CMD_CLEAR) ?
                       bdme_pkg::ST_CLEAR : bdme_pkg::ST_ROW;
        end
      end
      bdme_pkg::ST_ROW:     state_next = bdme_pkg::ST_COL;
      bdme_pkg::ST_COL:     state_next = bdme_pkg::ST_MUL_NEW;
      bdme_pkg::ST_MUL_NEW: state_next = bdme_pkg::ST_MUL_OLD;
      bdme_pkg::ST_MUL_OLD: state_next = bdme_pkg::ST_UPDATE;
      bdme_pkg::ST_UPDATE:  state_next = (delta != '0) ? bdme_pkg::ST_SQ_NEW : bdme_pkg::ST_ACC;
      bdme_pkg::ST_SQ_NEW:  state_next = bdme_pkg::ST_SQ_OLD;
      bdme_pkg::ST_SQ_OLD:  state_next = bdme_pkg::ST_ACC;
      bdme_pkg::ST_ACC: begin
        if (!last_col) begin
          state_next = bdme_pkg::ST_COL;
        end else if (!last_row) begin
          state_next = bdme_pkg::ST_ROW;
        end else begin
          state_next = bdme_pkg::ST_FINISH;
        end
      end
      bdme_pkg::ST_FINISH:  if (out_free) state_next = bdme_pkg::ST_IDLE;
      default:              state_next = bdme_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory write controls.
  always_comb begin
    in_stall  = (state != bdme_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_wdata = nocc_r;
    unique case (state)
      bdme_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      bdme_pkg::ST_ACC: mem_we = write_back && nz_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdme_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Walk state, accumulators and the shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      clr_reply <= 1'b0;
    end else begin
      unique case (state)
        bdme_pkg::ST_CLEAR: addr <= last_addr ? '0 : addr + AW'(1);
        bdme_pkg::ST_IDLE: begin
          if (in_acc) begin
            clr_reply <= (bdme_pkg::cmd_t'(command) == bdme_pkg::CMD_CLEAR);
            addr      <= '0;
          end
        end
        bdme_pkg::ST_ACC: begin
          if (!last_col) begin
            addr <= addr + AW'(1);
          end else begin
            addr <= row_base + AW'(MAX_COLS);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    unique case (state)
      bdme_pkg::ST_IDLE: begin
        cmd      <= bdme_pkg::cmd_t'(command);
        rect_w   <= PW'({1'b0, width});
        rect_h   <= PW'({1'b0, height});
        ol       <= PW'(old_left);
        ob       <= PW'(old_bottom);
        nl       <= PW'(new_left);
        nb       <= PW'(new_bottom);
        bx       <= '0;
        by       <= '0;
        bl       <= '0;
        bb       <= '0;
        row_base <= '0;
        ovf_acc  <= '0;
        sq_acc   <= '0;
        sat_acc  <= 1'b0;
      end
      bdme_pkg::ST_ROW: begin
        oy_new <= bdme_pkg::span_overlap(nb, nb + rect_h, bb, bb + PW'(pitch_y));
        oy_old <= use_old ? bdme_pkg::span_overlap(ob, ob + rect_h, bb, bb + PW'(pitch_y))
                          : '0;
      end
      bdme_pkg::ST_COL: begin
        ox_new <= bdme_pkg::span_overlap(nl, nl + rect_w, bl, bl + PW'(pitch_x));
        ox_old <= bdme_pkg::span_overlap(ol, ol + rect_w, bl, bl + PW'(pitch_x));
      end
      bdme_pkg::ST_MUL_OLD: a_new <= mul_p[bdme_pkg::AREA_W-1:0];
      bdme_pkg::ST_UPDATE: begin
        nz_r   <= (delta != '0);
        nocc_r <= upd.nocc;
        oex_r  <= upd.excess_before;
        nex_r  <= upd.excess_after;
        if (delta != '0 && upd.clip) begin
          sat_acc <= 1'b1;
        end
      end
      bdme_pkg::ST_SQ_OLD: sq_new <= mul_p;
      bdme_pkg::ST_ACC: begin
        if (nz_r) begin
          ovf_acc <= ovf_acc + bdme_pkg::OVA_W'($signed({1'b0, nex_r}))
                             - bdme_pkg::OVA_W'($signed({1'b0, oex_r}));
          sq_acc  <= sq_sat;
          if (sq_clip) begin
            sat_acc <= 1'b1;
          end
        end
        if (!last_col) begin
          bx <= bx + CXW'(1);
          bl <= bl + PW'(pitch_x);
        end else begin
          bx       <= '0;
          bl       <= '0;
          by       <= by + CYW'(1);
          bb       <= bb + PW'(pitch_y);
          row_base <= row_base + AW'(MAX_COLS);
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bdme_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bdme_pkg::ST_FINISH && out_free) begin
      if (clr_reply) begin
        overflow_delta      <= '0;
        excess_square_delta <= '0;
        saturated           <= 1'b0;
      end else begin
        overflow_delta      <= ovf_out;
        excess_square_delta <= sq_acc;
        saturated           <= sat_acc || ovf_clip;
      end
    end
  end

endmodule

>>> rtl/core/bdme_occ_update.sv
// Occupancy update of one bin: clamped new occupancy and old and new excess over capacity.
module bdme_occ_update (
  input  logic [bdme_pkg::OCC_W-1:0]         occ,
  input  logic signed [bdme_pkg::AREA_W:0]   delta,
  input  logic [bdme_pkg::CAP_W-1:0]         capacity,
  output bdme_pkg::occ_upd_t                 upd
);

  localparam int SUM_W = bdme_pkg::OCC_W + 2;

  logic signed [SUM_W-1:0] sum;
  logic [bdme_pkg::OCC_W-1:0] nocc;
  logic [bdme_pkg::OCC_W-1:0] cap_ext;

  assign cap_ext = {{(bdme_pkg::OCC_W - bdme_pkg::CAP_W){1'b0}}, capacity};

  // Add the signed area change, clamp to the occupancy range, and form the excess
  // over capacity before and after.
  always_comb begin
    sum = $signed({2'b00, occ}) + SUM_W'(delta);
    upd.clip = 1'b0;
    if (sum < 0) begin
      nocc = '0;
      upd.clip = 1'b1;
    end else if (sum > $signed({2'b00, bdme_pkg::OCC_MAX})) begin
      nocc = bdme_pkg::OCC_MAX;
      upd.clip = 1'b1;
    end else begin
      nocc = sum[bdme_pkg::OCC_W-1:0];
    end
    upd.nocc = nocc;
    upd.excess_before = (occ > cap_ext) ? occ - cap_ext : '0;
    upd.excess_after  = (nocc > cap_ext) ? nocc - cap_ext : '0;
  end

endmodule
